// ===== hdl/ycrgb_pkg.sv =====
package ycrgb_pkg;

  // Input and output word widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned InDataW = 3 * SampleW;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OutDataW = 3 * ByteW;

  // Coefficients in units of 1/10000
  localparam int CoefCrR  = 14022;
  localparam int CoefCrG  = -7145;
  localparam int CoefCbG  = -3456;
  localparam int CoefCbB  = 17710;
  localparam int CoefOne  = 10000;
  localparam int CoefHalf = 5000;

  // Chroma table: 256 entries, 9-bit signed products
  localparam int unsigned TabDepth = 256;
  localparam int unsigned TabW     = 9;

  typedef logic signed [TabW-1:0] tab_entry_t;
  typedef tab_entry_t tab_t [TabDepth];

  // One converted pixel
  typedef struct packed {
    logic [ByteW-1:0] blue;
    logic [ByteW-1:0] green;
    logic [ByteW-1:0] red;
  } rgb_t;

  // One input pixel, luma in the low bits
  typedef struct packed {
    logic signed [SampleW-1:0] chroma_red;
    logic signed [SampleW-1:0] chroma_blue;
    logic signed [SampleW-1:0] luma;
  } ycc_t;

  // Build a rounded coefficient table at elaboration, index = chroma + 128
  function automatic tab_t build_tab(input int k);
    tab_t t;
    int   c;
    for (int i = 0; i < TabDepth; i++) begin
      c    = i - (TabDepth / 2);
      t[i] = TabW'((k * c + CoefHalf) / CoefOne);
    end
    return t;
  endfunction

  localparam tab_t TabCrR = build_tab(CoefCrR);
  localparam tab_t TabCrG = build_tab(CoefCrG);
  localparam tab_t TabCbG = build_tab(CoefCbG);
  localparam tab_t TabCbB = build_tab(CoefCbB);

  // Clip a signed sum to 0..255
  function automatic logic [ByteW-1:0] clip_byte(input logic signed [13:0] v);
    logic [ByteW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 14'sd255) begin
      r = '1;
    end else begin
      r = v[ByteW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hdl/ycrgb_conv.sv =====
module ycrgb_conv (
  input  ycrgb_pkg::ycc_t pix_i,
  input  logic            color_en_i,
  output ycrgb_pkg::rgb_t rgb_o
);

  logic signed [11:0] luma_sh;
  logic signed [11:0] cb_sh;
  logic signed [11:0] cr_sh;
  logic signed [12:0] luma_off;
  logic [7:0]         cb_idx;
  logic [7:0]         cr_idx;
  logic signed [13:0] sum_r;
  logic signed [13:0] sum_g;
  logic signed [13:0] sum_b;
  logic [7:0]         gray;

  // Drop the four fraction bits
  assign luma_sh = pix_i.luma[15:4];
  assign cb_sh   = pix_i.chroma_blue[15:4];
  assign cr_sh   = pix_i.chroma_red[15:4];

  assign luma_off = 13'(luma_sh) + 13'sd128;

  // Saturate chroma to -128..127 and form the table index (offset by 128)
  always_comb begin
    if (cb_sh < -12'sd128) begin
      cb_idx = 8'h00;
    end else if (cb_sh > 12'sd127) begin
      cb_idx = 8'hff;
    end else begin
      cb_idx = {~cb_sh[7], cb_sh[6:0]};
    end
    if (cr_sh < -12'sd128) begin
      cr_idx = 8'h00;
    end else if (cr_sh > 12'sd127) begin
      cr_idx = 8'hff;
    end else begin
      cr_idx = {~cr_sh[7], cr_sh[6:0]};
    end
  end

  // Sum luma with the table products
  assign sum_r = 14'(luma_off) + 14'(ycrgb_pkg::TabCrR[cr_idx]);
  assign sum_g = 14'(luma_off) + 14'(ycrgb_pkg::TabCrG[cr_idx])
               + 14'(ycrgb_pkg::TabCbG[cb_idx]);
  assign sum_b = 14'(luma_off) + 14'(ycrgb_pkg::TabCbB[cb_idx]);

  assign gray = ycrgb_pkg::clip_byte(14'(luma_off));

  // Pick color or gray output
  always_comb begin
    if (color_en_i) begin
      rgb_o.red   = ycrgb_pkg::clip_byte(sum_r);
      rgb_o.green = ycrgb_pkg::clip_byte(sum_g);
      rgb_o.blue  = ycrgb_pkg::clip_byte(sum_b);
    end else begin
      rgb_o.red   = gray;
      rgb_o.green = gray;
      rgb_o.blue  = gray;
    end
  end

endmodule

// ===== hdl/ycbcr_to_rgb_clipped_core.sv =====
// Channel   Dir  Word bits                                          Handshake
// s_axis    in   luma [15:0], chroma_blue [31:16], chroma_red [47:32]  tvalid/tready
// m_axis    out  red [7:0], green [15:8], blue [23:16]                 tvalid/tready
// cfg       in   color_enable [0]                                      cfg_we_i, no wait
//
// One pixel per clock sustained while m_axis is ready; a pixel goes from the input
// register to the result register, with the table lookup and clip between them.
// Reset clears both valid flags and sets color_enable to 1.
// A stall on m_axis fills the result register, then the input register,
// and only then drops s_axis_tready.
module ycbcr_to_rgb_clipped_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic                             cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // luma [15:0], chroma_blue [31:16], chroma_red [47:32]
  input  logic [ycrgb_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // red [7:0], green [15:8], blue [23:16]
  output logic [ycrgb_pkg::OutDataW-1:0]   m_axis_tdata
);

  logic            color_en_q;
  logic            in_vld_q;
  ycrgb_pkg::ycc_t in_pix_q;
  logic            out_vld_q;
  ycrgb_pkg::rgb_t out_rgb_q;
  ycrgb_pkg::rgb_t rgb_d;
  logic            adv_out;
  logic            take_in;

  // Hold the mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      color_en_q <= cfg_wdata_i;
    end
  end

  // Advance when the result register is empty or being drained
  assign adv_out       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv_out;
  assign take_in       = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_pix_q <= s_axis_tdata;
    end
  end

  ycrgb_conv u_conv (
    .pix_i      (in_pix_q),
    .color_en_i (color_en_q),
    .rgb_o      (rgb_d)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      out_rgb_q <= rgb_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_rgb_q;

endmodule

// ===== tb/ycbcr_to_rgb_clipped_core_test.sv =====
module ycbcr_to_rgb_clipped_core_test;

  // Fixed-point coefficients in units of 1/10000
  localparam int KCrRed   = 14022;
  localparam int KCrGreen = -7145;
  localparam int KCbGreen = -3456;
  localparam int KCbBlue  = 17710;
  localparam int KScale   = 10000;
  localparam int KRound   = 5000;
  localparam int LumaBias = 128;

  localparam int MaxShown = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;

  // Predicted pixels waiting for the output, oldest first
  ycrgb_pkg::rgb_t pending_rgb[$];
  bit   color_mode;
  int   mismatch_count;

  // Idling controls shared with the sink process
  bit src_idle_on;
  bit sink_idle_on;
  int hold_off_cycles;

  ycbcr_to_rgb_clipped_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Hard stop in case the pipeline hangs
  initial begin
    #400000;
    $display("ycbcr_to_rgb_clipped_core_test: done, errors");
    $finish;
  end

  // Saturate a shifted chroma sample to the table range
  function automatic int sat_chroma(int c);
    if (c < -128) return -128;
    if (c > 127) return 127;
    return c;
  endfunction

  // Rounded table term, division truncates toward zero
  function automatic int coef_term(int k, int c);
    return (k * c + KRound) / KScale;
  endfunction

  function automatic logic [7:0] clip_to_byte(int v);
    if (v < 0) return 8'd0;
    if (v > 255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic ycrgb_pkg::rgb_t ycc_to_rgb(ycrgb_pkg::ycc_t p, bit color);
    ycrgb_pkg::rgb_t o;
    int   y;
    int   cb;
    int   cr;
    y = (int'($signed(p.luma)) >>> 4) + LumaBias;
    if (!color) begin
      o.red   = clip_to_byte(y);
      o.green = o.red;
      o.blue  = o.red;
    end else begin
      cb      = sat_chroma(int'($signed(p.chroma_blue)) >>> 4);
      cr      = sat_chroma(int'($signed(p.chroma_red)) >>> 4);
      o.red   = clip_to_byte(y + coef_term(KCrRed, cr));
      o.green = clip_to_byte(y + coef_term(KCrGreen, cr) + coef_term(KCbGreen, cb));
      o.blue  = clip_to_byte(y + coef_term(KCbBlue, cb));
    end
    return o;
  endfunction

  function automatic ycrgb_pkg::ycc_t make_ycc(int l, int cb, int cr);
    ycrgb_pkg::ycc_t p;
    p.luma        = 16'(l);
    p.chroma_blue = 16'(cb);
    p.chroma_red  = 16'(cr);
    return p;
  endfunction

  // Mostly samples near the table and byte edges, some full-range noise
  function automatic ycrgb_pkg::ycc_t random_ycc();
    if ($urandom_range(0, 3) == 0) begin
      return make_ycc($urandom, $urandom, $urandom);
    end
    return make_ycc(int'($urandom_range(0, 4400)) - 2200,
                    int'($urandom_range(0, 4400)) - 2200,
                    int'($urandom_range(0, 4400)) - 2200);
  endfunction

  // Offer one pixel, hold it until taken, then record its prediction
  task automatic send_pixel(ycrgb_pkg::ycc_t p);
    bit taken;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= p;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end while (!taken);
    pending_rgb.push_back(ycc_to_rgb(p, color_mode));
  endtask

  // Drain the pipeline, then write color_enable
  task automatic set_color_mode(bit mode);
    s_axis_tvalid <= 1'b0;
    wait (pending_rgb.size() == 0);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    color_mode = mode;
  endtask

  // Sink: random ready bursts, idle bursts, and requested long holds
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_cycles - 1) @(posedge clk_i);
        hold_off_cycles = 0;
      end else if (sink_idle_on && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 15) - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20) - 1) @(posedge clk_i);
      end
    end
  end

  // Compare each output word with the oldest prediction
  always @(negedge clk_i) begin
    ycrgb_pkg::rgb_t got;
    ycrgb_pkg::rgb_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_rgb.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MaxShown) begin
          $display("unexpected word r=%0d g=%0d b=%0d", got.red, got.green, got.blue);
        end
      end else begin
        want = pending_rgb.pop_front();
        if (got.red != want.red || got.green != want.green || got.blue != want.blue) begin
          mismatch_count++;
          if (mismatch_count <= MaxShown) begin
            $display("pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     want.red, want.green, want.blue, got.red, got.green, got.blue);
          end
        end
      end
    end
  end

  // Edges of luma bias, chroma saturation and byte clipping
  task automatic test_directed_color();
    set_color_mode(1'b1);
    send_pixel(make_ycc(0, 0, 0));
    send_pixel(make_ycc(-32768, -32768, -32768));
    send_pixel(make_ycc(32767, 32767, 32767));
    send_pixel(make_ycc(-2048, 0, 0));
    send_pixel(make_ycc(-2064, 0, 0));
    send_pixel(make_ycc(2032, 0, 0));
    send_pixel(make_ycc(2048, 0, 0));
    send_pixel(make_ycc(0, -2048, 2032));
    send_pixel(make_ycc(0, -2049, 2048));
    send_pixel(make_ycc(0, -1, -1));
    send_pixel(make_ycc(0, -15, 15));
    send_pixel(make_ycc(0, 2032, -2048));
    send_pixel(make_ycc(1000, 2032, 2032));
    send_pixel(make_ycc(-1000, -2048, -2048));
    send_pixel(make_ycc(32767, -32768, 32767));
    send_pixel(make_ycc(-32768, 32767, -32768));
    send_pixel(make_ycc(21845, -21846, 21845));
  endtask

  // Gray mode: chroma must not matter
  task automatic test_directed_gray();
    set_color_mode(1'b0);
    send_pixel(make_ycc(-32768, 1, 2));
    send_pixel(make_ycc(32767, -32768, 32767));
    send_pixel(make_ycc(-2064, 2048, -2049));
    send_pixel(make_ycc(-2048, -21846, 21845));
    send_pixel(make_ycc(2032, 32767, -32768));
    send_pixel(make_ycc(2048, 0, 0));
    send_pixel(make_ycc(0, -1, -1));
  endtask

  // Random pixels over several mode settings
  task automatic test_random_modes();
    for (int phase = 0; phase < 6; phase++) begin
      set_color_mode((phase % 3) != 1);
      repeat (75) send_pixel(random_ycc());
    end
  endtask

  // Stall the output long enough that the input must stall too
  task automatic test_backpressure();
    set_color_mode(1'b1);
    src_idle_on     = 1'b0;
    hold_off_cycles = 60;
    repeat (40) send_pixel(random_ycc());
    src_idle_on = 1'b1;
  endtask

  // Full rate with no idling on either side
  task automatic test_full_rate();
    set_color_mode(1'b0);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (15) send_pixel(random_ycc());
    set_color_mode(1'b1);
    repeat (30) send_pixel(random_ycc());
  endtask

  initial begin
    rst_ni          <= 1'b0;
    cfg_we_i        <= 1'b0;
    cfg_wdata_i     <= 1'b0;
    s_axis_tvalid   <= 1'b0;
    s_axis_tdata    <= '0;
    color_mode      = 1'b1;
    mismatch_count  = 0;
    src_idle_on     = 1'b1;
    sink_idle_on    = 1'b1;
    hold_off_cycles = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of color_enable is checked before any write
    send_pixel(make_ycc(0, 2032, -2048));
    test_directed_color();
    test_directed_gray();
    test_random_modes();
    test_backpressure();
    test_full_rate();

    // Drain and let the pipeline settle
    s_axis_tvalid <= 1'b0;
    wait (pending_rgb.size() == 0);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_rgb.size() == 0) begin
      $display("ycbcr_to_rgb_clipped_core_test: done, clean");
    end else begin
      $display("ycbcr_to_rgb_clipped_core_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ycrgb_pkg.sv
hdl/ycrgb_conv.sv
hdl/ycbcr_to_rgb_clipped_core.sv
tb/ycbcr_to_rgb_clipped_core_test.sv
